@@ rtl/apq_pkg.sv @@
`default_nettype none

package apq_pkg;

  localparam int unsigned DEPTH     = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LEAVES    = 1 << IDX_W;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CNT_OUT_W = 4;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] info_in;
    logic signed [DATA_W-1:0] prio_in;
  } apq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] info_out;
    logic signed [DATA_W-1:0] prio_out;
    logic [CNT_OUT_W-1:0]     count_out;
  } apq_out_t;

  typedef struct packed {
    logic load;
    logic find;
    logic exec;
  } apq_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_EXEC,
    ST_DONE
  } apq_state_e;

endpackage

`default_nettype wire

@@ rtl/apq_ctrl.sv @@
`default_nettype none

module apq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output apq_pkg::apq_cmd_t      cmd_o
);

  apq_pkg::apq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      apq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = apq_pkg::ST_FIND;
        end
      end
      apq_pkg::ST_FIND: state_d = apq_pkg::ST_EXEC;
      apq_pkg::ST_EXEC: state_d = apq_pkg::ST_DONE;
      apq_pkg::ST_DONE: begin
        if (!out_stall_i) begin
          state_d = apq_pkg::ST_IDLE;
        end
      end
      default: state_d = apq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      apq_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      apq_pkg::ST_FIND: cmd_o.find = 1'b1;
      apq_pkg::ST_EXEC: cmd_o.exec = 1'b1;
      apq_pkg::ST_DONE: out_valid_o = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/apq_dp.sv @@
`default_nettype none

module apq_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire apq_pkg::apq_cmd_t cmd_i,
  input  wire apq_pkg::apq_in_t  in_data_i,
  output apq_pkg::apq_out_t      out_data_o
);

  localparam int unsigned DEPTH  = apq_pkg::DEPTH;
  localparam int unsigned DATA_W = apq_pkg::DATA_W;
  localparam int unsigned IDX_W  = apq_pkg::IDX_W;
  localparam int unsigned LEAVES = apq_pkg::LEAVES;
  localparam int unsigned CNT_W  = apq_pkg::CNT_W;

  apq_pkg::apq_in_t    op_q;
  logic [DATA_W-1:0]   entry_info_q [DEPTH];
  logic [DATA_W-1:0]   entry_prio_q [DEPTH];
  logic [DATA_W-1:0]   entry_info_d [DEPTH];
  logic [DATA_W-1:0]   entry_prio_d [DEPTH];
  logic [DATA_W-1:0]   next_info    [DEPTH];
  logic [DATA_W-1:0]   next_prio    [DEPTH];
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    best_q;
  apq_pkg::apq_out_t   out_q, out_d;

  logic                leaf_vld  [LEAVES];
  logic [DATA_W-1:0]   leaf_prio [LEAVES];
  logic                node_vld  [2*LEAVES];
  logic [DATA_W-1:0]   node_prio [2*LEAVES];
  logic [IDX_W-1:0]    node_idx  [2*LEAVES];

  logic                is_full;
  logic                is_empty;
  logic                do_insert;
  logic                do_delete;

  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < DEPTH) begin : g_real
      assign leaf_vld[g]  = CNT_W'(g) < count_q;
      assign leaf_prio[g] = entry_prio_q[g];
    end else begin : g_pad
      assign leaf_vld[g]  = 1'b0;
      assign leaf_prio[g] = '0;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_next
    if (g + 1 < DEPTH) begin : g_mid
      assign next_info[g] = entry_info_q[g+1];
      assign next_prio[g] = entry_prio_q[g+1];
    end else begin : g_last
      assign next_info[g] = entry_info_q[g];
      assign next_prio[g] = entry_prio_q[g];
    end
  end

  // Ties keep the left child, which holds the earlier arrivals.
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      node_vld[LEAVES+i]  = leaf_vld[i];
      node_prio[LEAVES+i] = leaf_prio[i];
      node_idx[LEAVES+i]  = IDX_W'(i);
    end
    node_vld[0]  = 1'b0;
    node_prio[0] = '0;
    node_idx[0]  = '0;
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (node_vld[2*n+1] && (!node_vld[2*n] ||
          ($signed(node_prio[2*n+1]) > $signed(node_prio[2*n])))) begin
        node_vld[n]  = 1'b1;
        node_prio[n] = node_prio[2*n+1];
        node_idx[n]  = node_idx[2*n+1];
      end else begin
        node_vld[n]  = node_vld[2*n];
        node_prio[n] = node_prio[2*n];
        node_idx[n]  = node_idx[2*n];
      end
    end
  end

  assign is_full   = count_q == CNT_W'(DEPTH);
  assign is_empty  = count_q == '0;
  assign do_insert = cmd_i.exec && (op_q.mode == apq_pkg::MODE_INSERT) && !is_full;
  assign do_delete = cmd_i.exec && (op_q.mode == apq_pkg::MODE_DELETE) && !is_empty;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_info_d[i] = entry_info_q[i];
      entry_prio_d[i] = entry_prio_q[i];
      if (do_insert && (CNT_W'(i) == count_q)) begin
        entry_info_d[i] = op_q.info_in;
        entry_prio_d[i] = op_q.prio_in;
      end else if (do_delete && (IDX_W'(i) >= best_q)) begin
        entry_info_d[i] = next_info[i];
        entry_prio_d[i] = next_prio[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_delete) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_d          = '0;
    out_d.status   = apq_pkg::STATUS_DONE;
    out_d.count_out = apq_pkg::CNT_OUT_W'(count_d);
    case (op_q.mode)
      apq_pkg::MODE_INSERT: begin
        if (is_full) begin
          out_d.status = apq_pkg::STATUS_FULL;
        end
      end
      apq_pkg::MODE_DELETE: begin
        if (is_empty) begin
          out_d.status = apq_pkg::STATUS_EMPTY;
        end else begin
          out_d.info_out = entry_info_q[best_q];
          out_d.prio_out = entry_prio_q[best_q];
        end
      end
      apq_pkg::MODE_PEEK: begin
        if (is_empty) begin
          out_d.status = apq_pkg::STATUS_EMPTY;
        end else begin
          out_d.prio_out = entry_prio_q[best_q];
        end
      end
      default: out_d.status = apq_pkg::STATUS_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_data_i;
    end
    if (cmd_i.find) begin
      best_q <= node_idx[1];
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
    for (int i = 0; i < DEPTH; i++) begin
      entry_info_q[i] <= entry_info_d[i];
      entry_prio_q[i] <= entry_prio_d[i];
    end
  end

  assign out_data_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("Accepted insert did not add an entry.");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_delete |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("Successful delete did not remove an entry.");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> count_q == $past(count_q))
    else $error("Entry count changed outside an operation.");

endmodule

`default_nettype wire

@@ rtl/array_priority_queue_top.sv @@
// A result is offered in the controller's done state, after the find and execute
// states, and is held there while the result side stalls.
// A new operation is taken only once the last result has transferred;
// the controller takes one operation at a time through find, execute and hand-off.
// The greatest priority is found by a combinational compare tree over all entries.
// Reset clears the entry count and the controller; stored entries are not cleared.
`default_nettype none

module array_priority_queue_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire apq_pkg::apq_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output apq_pkg::apq_out_t     out_data_o
);

  apq_pkg::apq_cmd_t cmd;

  apq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  apq_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire

@@ sim/array_priority_queue_top_tb.sv @@
`timescale 1ns / 1ps

module array_priority_queue_top_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_OPS = 1300;
  localparam int unsigned QUIET_OPS = 150;
  localparam int unsigned LONG_HOLD = 80;

  class pq_scoreboard;
    logic signed [apq_pkg::DATA_W-1:0] held_info[apq_pkg::DEPTH];
    logic signed [apq_pkg::DATA_W-1:0] held_prio[apq_pkg::DEPTH];
    int unsigned held_count;
    apq_pkg::apq_out_t expected_q[$];
    int unsigned errors;

    function new();
      held_count = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_op(apq_pkg::apq_in_t op);
      apq_pkg::apq_out_t res;
      int unsigned best;
      res = '0;
      res.status = apq_pkg::STATUS_DONE;
      case (op.mode)
        apq_pkg::MODE_INSERT: begin
          if (held_count >= apq_pkg::DEPTH) begin
            res.status = apq_pkg::STATUS_FULL;
          end else begin
            held_info[held_count] = op.info_in;
            held_prio[held_count] = op.prio_in;
            held_count++;
          end
        end
        apq_pkg::MODE_DELETE, apq_pkg::MODE_PEEK: begin
          if (held_count == 0) begin
            res.status = apq_pkg::STATUS_EMPTY;
          end else begin
            best = 0;
            for (int unsigned i = 1; i < held_count; i++) begin
              if (held_prio[i] > held_prio[best]) best = i;
            end
            res.prio_out = held_prio[best];
            if (op.mode == apq_pkg::MODE_DELETE) begin
              res.info_out = held_info[best];
              for (int unsigned i = best; i + 1 < held_count; i++) begin
                held_info[i] = held_info[i+1];
                held_prio[i] = held_prio[i+1];
              end
              held_count--;
            end
          end
        end
        default: ;
      endcase
      res.count_out = apq_pkg::CNT_OUT_W'(held_count);
      expected_q.push_back(res);
    endfunction

    function void check_field(string name, logic signed [apq_pkg::DATA_W:0] want,
                              logic signed [apq_pkg::DATA_W:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(apq_pkg::apq_out_t got);
      apq_pkg::apq_out_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing outstanding: %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("status", want.status, got.status);
      check_field("info_out", want.info_out, got.info_out);
      check_field("prio_out", want.prio_out, got.prio_out);
      check_field("count_out", want.count_out, got.count_out);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  apq_pkg::apq_in_t in_data = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  apq_pkg::apq_out_t out_data_o;

  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int unsigned cycles = 0;
  pq_scoreboard sb = new();

  array_priority_queue_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("array_priority_queue_top_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) sb.note_op(in_data);
      if (out_valid_o && !out_stall) sb.check_result(out_data_o);
    end
  end

  // The result side stalls in short random bursts, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic apq_pkg::apq_in_t make_op(logic [1:0] mode,
                                               logic signed [apq_pkg::DATA_W-1:0] info,
                                               logic signed [apq_pkg::DATA_W-1:0] prio);
    apq_pkg::apq_in_t op;
    op.mode = mode;
    op.info_in = info;
    op.prio_in = prio;
    return op;
  endfunction

  function automatic logic signed [apq_pkg::DATA_W-1:0] random_prio();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 7)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic transfer_op(input apq_pkg::apq_in_t op);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    do @(posedge clk); while (in_stall_o);
  endtask

  initial begin
    int unsigned insert_pct;
    int unsigned pick;
    logic [1:0] mode;
    insert_pct = 50;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Empty queue: peek, delete and an unused mode.
    transfer_op(make_op(apq_pkg::MODE_PEEK, 32'sd11, 32'sd12));
    transfer_op(make_op(apq_pkg::MODE_DELETE, 32'sd13, 32'sd14));
    transfer_op(make_op(MODE_UNUSED, 32'sd15, 32'sd16));
    // Fill with extremes and ties on both the largest and smallest priority.
    transfer_op(make_op(apq_pkg::MODE_INSERT, 32'sh7fffffff, 32'sd0));
    transfer_op(make_op(apq_pkg::MODE_INSERT, 32'sh80000000, 32'sh7fffffff));
    transfer_op(make_op(apq_pkg::MODE_INSERT, 32'sd1, 32'sh80000000));
    transfer_op(make_op(apq_pkg::MODE_INSERT, 32'sd2, 32'sh7fffffff));
    transfer_op(make_op(apq_pkg::MODE_INSERT, -32'sd1, -32'sd1));
    transfer_op(make_op(apq_pkg::MODE_INSERT, 32'sd3, 32'sd5));
    transfer_op(make_op(apq_pkg::MODE_INSERT, 32'sd4, 32'sh80000000));
    transfer_op(make_op(apq_pkg::MODE_INSERT, 32'sd5, 32'sd5));
    transfer_op(make_op(apq_pkg::MODE_INSERT, 32'sd6, 32'sd7));
    transfer_op(make_op(apq_pkg::MODE_PEEK, 32'sh55555555, 32'shaaaaaaaa));
    transfer_op(make_op(MODE_UNUSED, 32'shaaaaaaaa, 32'sh55555555));
    repeat (9) transfer_op(make_op(apq_pkg::MODE_DELETE, 32'sd0, 32'sd0));

    for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
      if (i % 40 == 0) insert_pct = $urandom_range(15, 85);
      if (i == 400) long_hold_req = 1'b1;
      if (i == RANDOM_OPS - QUIET_OPS) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 4) mode = MODE_UNUSED;
      else if (pick < 14) mode = apq_pkg::MODE_PEEK;
      else if (pick < 14 + insert_pct * 86 / 100) mode = apq_pkg::MODE_INSERT;
      else mode = apq_pkg::MODE_DELETE;
      transfer_op(make_op(mode, $urandom, random_prio()));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("array_priority_queue_top_tb: done, clean");
    end else begin
      $display("array_priority_queue_top_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/apq_pkg.sv
rtl/apq_ctrl.sv
rtl/apq_dp.sv
rtl/array_priority_queue_top.sv
sim/array_priority_queue_top_tb.sv
